/* rtl/bdpc_pkg.sv */
// shared types and constants of the button debounce press classifier
`default_nettype none

package bdpc_pkg;

  localparam int SLOTS       = 4;
  localparam int LEVEL_W     = 8;
  localparam int THRESH_W    = 7;
  localparam int TICKS_W     = 16;
  localparam int COUNT_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ACK_LEVEL        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEVEL        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LEVEL        = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 2'd3;

  typedef struct packed {
    logic [THRESH_W-1:0]       ack_level;
    logic [THRESH_W-1:0]       max_level;
    logic signed [LEVEL_W-1:0] min_level;
    logic [TICKS_W-1:0]        long_press_ticks;
  } lane_cfg_t;

  typedef struct packed {
    logic               short_ev;
    logic               long_ev;
    logic               tracking;
    logic [COUNT_W-1:0] short_count;
    logic [COUNT_W-1:0] long_count;
  } lane_res_t;

endpackage

`default_nettype wire

/* rtl/bdpc_if.sv */
// tick and result channel interfaces
`default_nettype none

interface bdpc_tick_if;
  logic       valid;
  logic       ready;
  logic [3:0] edge_mask;
  logic [3:0] pin_levels;

  modport source (output valid, output edge_mask, output pin_levels, input ready);
  modport sink (input valid, input edge_mask, input pin_levels, output ready);
endinterface

interface bdpc_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  short_event_mask;
  logic [3:0]  long_event_mask;
  logic        any_tracking;
  logic [15:0] short_count_a;
  logic [15:0] short_count_b;
  logic [15:0] short_count_c;
  logic [15:0] short_count_d;
  logic [15:0] long_count_a;
  logic [15:0] long_count_b;
  logic [15:0] long_count_c;
  logic [15:0] long_count_d;

  modport source (
    output valid, output short_event_mask, output long_event_mask, output any_tracking,
    output short_count_a, output short_count_b, output short_count_c, output short_count_d,
    output long_count_a, output long_count_b, output long_count_c, output long_count_d,
    input ready
  );
  modport sink (
    input valid, input short_event_mask, input long_event_mask, input any_tracking,
    input short_count_a, input short_count_b, input short_count_c, input short_count_d,
    input long_count_a, input long_count_b, input long_count_c, input long_count_d,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/bdpc_lane.sv */
// per-button lane: level integrator, press timer and press counters
`default_nettype none

module bdpc_lane (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bdpc_pkg::lane_cfg_t cfg,
  input  wire logic              upd,
  input  wire logic              edge_bit,
  input  wire logic              pin_bit,
  output bdpc_pkg::lane_res_t    res
);
  import bdpc_pkg::*;

  logic                      tracking;
  logic                      acknowledged;
  logic signed [LEVEL_W-1:0] level;
  logic [TICKS_W-1:0]        press_ticks;
  logic [COUNT_W-1:0]        short_count;
  logic [COUNT_W-1:0]        long_count;

  logic                      tracking_next;
  logic                      acknowledged_next;
  logic signed [LEVEL_W-1:0] level_next;
  logic [TICKS_W-1:0]        press_ticks_next;
  logic [COUNT_W-1:0]        short_count_next;
  logic [COUNT_W-1:0]        long_count_next;

  logic                      start;
  logic                      cur_trk;
  logic signed [LEVEL_W-1:0] cur_level;
  logic [TICKS_W-1:0]        cur_ticks;
  logic [TICKS_W-1:0]        ticks_inc;
  logic signed [LEVEL_W:0]   lvl_step;
  logic signed [LEVEL_W:0]   lvl_clamp;
  logic signed [LEVEL_W:0]   ack_ext;
  logic signed [LEVEL_W:0]   max_ext;
  logic signed [LEVEL_W:0]   min_ext;
  logic                      hit_ack;
  logic                      above_max;
  logic                      ends;
  logic                      ack_set;
  logic                      is_long;
  logic                      short_ev;
  logic                      long_ev;

  // an edge on an idle button restarts the integrator and timer
  assign start     = edge_bit && !tracking;
  assign cur_trk   = tracking || edge_bit;
  assign cur_level = start ? '0 : level;
  assign cur_ticks = start ? '0 : press_ticks;

  assign ack_ext = $signed({2'b00, cfg.ack_level});
  assign max_ext = $signed({2'b00, cfg.max_level});
  assign min_ext = $signed({cfg.min_level[LEVEL_W-1], cfg.min_level});

  always_comb begin
    if (pin_bit) begin
      lvl_step = $signed({cur_level[LEVEL_W-1], cur_level}) - 9'sd1;
    end else begin
      lvl_step = $signed({cur_level[LEVEL_W-1], cur_level}) + 9'sd1;
    end
  end

  assign ticks_inc = (cur_ticks != {TICKS_W{1'b1}}) ? cur_ticks + 1'b1 : cur_ticks;
  assign hit_ack   = lvl_step >= ack_ext;
  assign above_max = lvl_step > max_ext;
  assign ends      = !above_max && (lvl_step < min_ext);
  assign ack_set   = acknowledged || hit_ack;
  assign is_long   = ticks_inc > cfg.long_press_ticks;
  assign lvl_clamp = above_max ? max_ext : lvl_step;
  assign short_ev  = cur_trk && ends && ack_set && !is_long;
  assign long_ev   = cur_trk && ends && ack_set && is_long;

  always_comb begin
    tracking_next     = tracking;
    acknowledged_next = acknowledged;
    level_next        = level;
    press_ticks_next  = press_ticks;
    short_count_next  = short_count + COUNT_W'(short_ev);
    long_count_next   = long_count + COUNT_W'(long_ev);
    if (cur_trk) begin
      tracking_next     = !ends;
      acknowledged_next = ends ? 1'b0 : ack_set;
      press_ticks_next  = ticks_inc;
      // saturate the stored level to its signed width
      if (lvl_clamp < -9'sd128) begin
        level_next = -8'sd128;
      end else if (lvl_clamp > 9'sd127) begin
        level_next = 8'sd127;
      end else begin
        level_next = lvl_clamp[LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking     <= 1'b0;
      acknowledged <= 1'b0;
      level        <= '0;
      press_ticks  <= '0;
      short_count  <= '0;
      long_count   <= '0;
    end else if (upd) begin
      tracking     <= tracking_next;
      acknowledged <= acknowledged_next;
      level        <= level_next;
      press_ticks  <= press_ticks_next;
      short_count  <= short_count_next;
      long_count   <= long_count_next;
    end
  end

  assign res.short_ev    = short_ev;
  assign res.long_ev     = long_ev;
  assign res.tracking    = tracking_next;
  assign res.short_count = short_count_next;
  assign res.long_count  = long_count_next;

  a_idle_not_acked: assert property (@(posedge clk) disable iff (rst)
    !tracking |-> !acknowledged)
    else $error("acknowledged set on an idle button");

  a_event_needs_ack: assert property (@(posedge clk) disable iff (rst)
    upd && (res.short_ev || res.long_ev) |-> (acknowledged || hit_ack) && !res.tracking)
    else $error("press event without acknowledge or while still tracking");

  a_ticks_after_tracked: assert property (@(posedge clk) disable iff (rst)
    upd && tracking |=> press_ticks != '0)
    else $error("press timer zero after a tracked tick");

endmodule

`default_nettype wire

/* rtl/bdpc_merge.sv */
// merges lane results into the registered result item
`default_nettype none

module bdpc_merge (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire bdpc_pkg::lane_res_t lane_res [bdpc_pkg::SLOTS],
  output logic                   take_ok,
  bdpc_result_if.source          result
);
  import bdpc_pkg::*;

  logic               valid;
  logic [SLOTS-1:0]   short_mask;
  logic [SLOTS-1:0]   long_mask;
  logic [SLOTS-1:0]   trk_mask;
  logic [SLOTS-1:0]   short_mask_q;
  logic [SLOTS-1:0]   long_mask_q;
  logic               any_q;
  logic [COUNT_W-1:0] short_q [SLOTS];
  logic [COUNT_W-1:0] long_q [SLOTS];

  always_comb begin
    for (int b = 0; b < SLOTS; b++) begin
      short_mask[b] = lane_res[b].short_ev;
      long_mask[b]  = lane_res[b].long_ev;
      trk_mask[b]   = lane_res[b].tracking;
    end
  end

  // output register frees as the held result is taken
  assign take_ok = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      short_mask_q <= short_mask;
      long_mask_q  <= long_mask;
      any_q        <= |trk_mask;
      for (int b = 0; b < SLOTS; b++) begin
        short_q[b] <= lane_res[b].short_count;
        long_q[b]  <= lane_res[b].long_count;
      end
    end
  end

  assign result.valid            = valid;
  assign result.short_event_mask = short_mask_q;
  assign result.long_event_mask  = long_mask_q;
  assign result.any_tracking     = any_q;
  assign result.short_count_a    = short_q[0];
  assign result.short_count_b    = short_q[1];
  assign result.short_count_c    = short_q[2];
  assign result.short_count_d    = short_q[3];
  assign result.long_count_a     = long_q[0];
  assign result.long_count_b     = long_q[1];
  assign result.long_count_c     = long_q[2];
  assign result.long_count_d     = long_q[3];

  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> valid)
    else $error("accepted request produced no result");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> take_ok)
    else $error("result overwritten before taken");

  a_events_disjoint: assert property (@(posedge clk) disable iff (rst)
    valid |-> (short_mask_q & long_mask_q) == '0)
    else $error("button reported as short and long at once");

endmodule

`default_nettype wire

/* rtl/button_debounce_press_classifier_core.sv */
// top level: one lane per button, result register, configuration registers
// latency: a result is valid the cycle after its request is accepted
// throughput: one request per cycle while results are taken; lanes update on each accepted request
// a held result blocks requests until it is taken, one enters in that same cycle
// reset (rst, synchronous): all button state and counters clear, registers
// return to ack 20, max 50, min 0, long press 1000 ticks
`default_nettype none

module button_debounce_press_classifier_core #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [bdpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  bdpc_tick_if.sink                             tick,
  bdpc_result_if.source                         result
);
  import bdpc_pkg::*;

  lane_cfg_t cfg;
  lane_res_t lane_res [SLOTS];
  logic      take_ok;
  logic      accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_level        <= THRESH_W'(20);
      cfg.max_level        <= THRESH_W'(50);
      cfg.min_level        <= '0;
      cfg.long_press_ticks <= TICKS_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACK_LEVEL:        cfg.ack_level        <= cfg_data[THRESH_W-1:0];
        REG_MAX_LEVEL:        cfg.max_level        <= cfg_data[THRESH_W-1:0];
        REG_MIN_LEVEL:        cfg.min_level        <= $signed(cfg_data[LEVEL_W-1:0]);
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data[TICKS_W-1:0];
      endcase
    end
  end

  assign tick.ready = take_ok;
  assign accept     = tick.valid && take_ok;

  for (genvar b = 0; b < SLOTS; b++) begin : g_lane
    if (b < NUM_BUTTONS) begin : g_live
      bdpc_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .cfg      (cfg),
        .upd      (accept),
        .edge_bit (tick.edge_mask[b]),
        .pin_bit  (tick.pin_levels[b]),
        .res      (lane_res[b])
      );
    end else begin : g_unused
      assign lane_res[b] = '0;
    end
  end

  bdpc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .lane_res (lane_res),
    .take_ok  (take_ok),
    .result   (result)
  );

endmodule

`default_nettype wire
